[rtl/rdp_pkg.sv]
// Package for the RSA decryption block: controller states, command and
// status structs, and the fixed ciphertext width. No dependencies.
`default_nettype none
package rdp_pkg;

  localparam int CT_W = 63;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KEY_N, ST_KEY_T, ST_EUC_INIT, ST_EUC_TEST, ST_EUC_WAIT,
    ST_INV_START, ST_INV_WAIT, ST_KEY_DONE, ST_RED_START, ST_RED_WAIT,
    ST_EXP_CHECK, ST_MULA_WAIT, ST_EXP_SQ, ST_MULB_WAIT, ST_DONE
  } state_t;

  typedef enum logic [1:0] {DIV_EUC, DIV_INV, DIV_RED} div_sel_t;
  typedef enum logic {MUL_ANS, MUL_SQ} mul_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     key_mul_n;
    logic     key_mul_t;
    logic     pe_clear;
    logic     euc_init;
    logic     div_start;
    div_sel_t div_sel;
    logic     euc_upd;
    logic     inv_fix;
    logic     key_set;
    logic     red_load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     mul_wb;
    logic     d_shift;
    logic     out_push;
  } cmd_t;

  typedef struct packed {
    logic key_ready;
    logic tot_zero;
    logic r1_zero;
    logic pe_zero;
    logic mod_zero;
    logic div_done;
    logic mul_done;
    logic d_lsb;
    logic d_last;
  } status_t;

endpackage
`default_nettype wire

[rtl/rdp_div.sv]
// Restoring divider, one quotient bit per cycle, that also accumulates
// quotient * mult_in modulo 2^SW. Depends on rdp_pkg.
`default_nettype none
module rdp_div #(
  parameter int MB = 62,
  parameter int SW = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [rdp_pkg::CT_W-1:0] dividend,
  input  wire logic [MB-1:0]           divisor,
  input  wire logic [SW-1:0]           mult_in,
  output logic      [MB-1:0]           rem,
  output logic      [SW-1:0]           qs,
  output logic                         done
);
  import rdp_pkg::*;
  localparam int CW = $clog2(CT_W);

  logic [CT_W-1:0] dvd;
  logic [MB-1:0]   dsr;
  logic [SW-1:0]   mi;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [MB:0]     t;
  logic [MB:0]     tsub;
  logic            ge;

  always_comb begin
    t    = {rem, dvd[CT_W-1]};
    tsub = t - {1'b0, dsr};
    ge   = (t >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(CT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      mi  <= mult_in;
      rem <= '0;
      qs  <= '0;
    end else if (busy) begin
      dvd <= {dvd[CT_W-2:0], 1'b0};
      rem <= ge ? tsub[MB-1:0] : t[MB-1:0];
      qs  <= {qs[SW-2:0], 1'b0} + (ge ? mi : '0);
    end
  end
endmodule
`default_nettype wire

[rtl/rdp_dp.sv]
// Datapath: key registers, extended Euclid registers, divider, bit-serial
// modular multiplier and exponent registers. Depends on rdp_pkg, rdp_div.
`default_nettype none
module rdp_dp #(
  parameter int MB = 62
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire rdp_pkg::cmd_t           cmd,
  output rdp_pkg::status_t             sts,
  input  wire logic                    cfg_clear,
  input  wire logic [31:0]             pub_e,
  input  wire logic [30:0]             prime_p,
  input  wire logic [30:0]             prime_q,
  input  wire logic [rdp_pkg::CT_W-1:0] ciphertext,
  output logic      [MB-1:0]           result
);
  import rdp_pkg::*;
  localparam int SW  = MB + 2;
  localparam int MCW = $clog2(MB + 1);

  logic [CT_W-1:0] ct;
  logic [MB-1:0]   modulus, totient, pe;
  logic            key_ready;
  logic [CT_W-1:0] r0;
  logic [MB-1:0]   r1;
  logic [SW-1:0]   s0, s1, s0_abs;
  logic [30:0]     ma, mb_op;
  logic [61:0]     prod;
  logic [CT_W-1:0] div_dvd;
  logic [MB-1:0]   div_dsr, div_rem;
  logic [SW-1:0]   div_qs;
  logic            div_done;
  logic [MB-1:0]   ans, base, d;
  logic [MB-1:0]   acc, mx, my;
  logic [MCW-1:0]  mcnt;
  logic            mbusy, mdone;
  logic [MB:0]     a2, a2s, sm, sms;
  logic [MB-1:0]   a2r, acc_next;

  always_comb begin
    ma    = cmd.key_mul_t ? ((prime_p == '0) ? '0 : prime_p - 31'd1) : prime_p;
    mb_op = cmd.key_mul_t ? ((prime_q == '0) ? '0 : prime_q - 31'd1) : prime_q;
    prod  = {31'd0, ma} * {31'd0, mb_op};
  end

  always_comb begin
    s0_abs = s0[SW-1] ? (SW'(0) - s0) : s0;
    case (cmd.div_sel)
      DIV_EUC: begin
        div_dvd = r0;
        div_dsr = r1;
      end
      DIV_INV: begin
        div_dvd = CT_W'(s0_abs[MB-1:0]);
        div_dsr = totient;
      end
      default: begin
        div_dvd = ct;
        div_dsr = modulus;
      end
    endcase
  end

  rdp_div #(.MB(MB), .SW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .mult_in  (s1),
    .rem      (div_rem),
    .qs       (div_qs),
    .done     (div_done)
  );

  // interleaved multiply, per bit of y from the MSB: acc = 2*acc mod m, then + x mod m if the bit is set
  always_comb begin
    a2       = {acc, 1'b0};
    a2s      = a2 - {1'b0, modulus};
    a2r      = (a2 >= {1'b0, modulus}) ? a2s[MB-1:0] : a2[MB-1:0];
    sm       = {1'b0, a2r} + {1'b0, mx};
    sms      = sm - {1'b0, modulus};
    acc_next = my[MB-1] ? ((sm >= {1'b0, modulus}) ? sms[MB-1:0] : sm[MB-1:0]) : a2r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_ready <= 1'b0;
      mbusy     <= 1'b0;
      mdone     <= 1'b0;
      mcnt      <= '0;
    end else begin
      mdone <= 1'b0;
      if (cfg_clear) begin
        key_ready <= 1'b0;
      end else if (cmd.key_set) begin
        key_ready <= 1'b1;
      end
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mcnt  <= MCW'(MB);
      end else if (mbusy) begin
        mcnt <= mcnt - MCW'(1);
        if (mcnt == MCW'(1)) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) ct <= ciphertext;
    if (cmd.key_mul_n) modulus <= prod[MB-1:0];
    if (cmd.key_mul_t) totient <= prod[MB-1:0];
    if (cmd.euc_init) begin
      r0 <= CT_W'(pub_e);
      r1 <= totient;
      s0 <= SW'(1);
      s1 <= '0;
    end else if (cmd.euc_upd) begin
      r0 <= CT_W'(r1);
      r1 <= div_rem;
      s0 <= s1;
      s1 <= s0 - div_qs;
    end
    if (cmd.pe_clear) begin
      pe <= '0;
    end else if (cmd.inv_fix) begin
      pe <= s0[SW-1] ? ((div_rem == '0) ? '0 : totient - div_rem) : div_rem;
    end
    if (cmd.red_load) begin
      base <= div_rem;
      ans  <= (modulus == MB'(1)) ? '0 : MB'(1);
      d    <= pe;
    end else begin
      if (cmd.d_shift) d <= {1'b0, d[MB-1:1]};
      if (cmd.mul_wb) begin
        if (cmd.mul_sel == MUL_ANS) ans <= acc;
        else base <= acc;
      end
    end
    if (cmd.mul_start) begin
      acc <= '0;
      mx  <= (cmd.mul_sel == MUL_ANS) ? ans : base;
      my  <= base;
    end else if (mbusy) begin
      acc <= acc_next;
      my  <= {my[MB-2:0], 1'b0};
    end
  end

  always_comb begin
    sts.key_ready = key_ready;
    sts.tot_zero  = (totient == '0);
    sts.r1_zero   = (r1 == '0);
    sts.pe_zero   = (pe == '0);
    sts.mod_zero  = (modulus == '0);
    sts.div_done  = div_done;
    sts.mul_done  = mdone;
    sts.d_lsb     = d[0];
    sts.d_last    = (d[MB-1:1] == '0);
    if (pe == '0) result = MB'(1);
    else if (modulus == '0) result = '0;
    else result = ans;
  end
endmodule
`default_nettype wire

[rtl/rdp_ctrl.sv]
// Controller state machine sequencing key derivation, reduction and
// square-and-multiply. Depends on rdp_pkg.
`default_nettype none
module rdp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             out_free,
  input  wire rdp_pkg::status_t sts,
  output rdp_pkg::cmd_t         cmd
);
  import rdp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = sts.key_ready ? ST_RED_START : ST_KEY_N;
      ST_KEY_N:     state_next = ST_KEY_T;
      ST_KEY_T:     state_next = ST_EUC_INIT;
      ST_EUC_INIT:  state_next = sts.tot_zero ? ST_KEY_DONE : ST_EUC_TEST;
      ST_EUC_TEST:  state_next = sts.r1_zero ? ST_INV_START : ST_EUC_WAIT;
      ST_EUC_WAIT:  if (sts.div_done) state_next = ST_EUC_TEST;
      ST_INV_START: state_next = ST_INV_WAIT;
      ST_INV_WAIT:  if (sts.div_done) state_next = ST_KEY_DONE;
      ST_KEY_DONE:  state_next = ST_RED_START;
      ST_RED_START: state_next = (sts.pe_zero || sts.mod_zero) ? ST_DONE : ST_RED_WAIT;
      ST_RED_WAIT:  if (sts.div_done) state_next = ST_EXP_CHECK;
      ST_EXP_CHECK: state_next = sts.d_lsb ? ST_MULA_WAIT : ST_EXP_SQ;
      ST_MULA_WAIT: if (sts.mul_done) state_next = ST_EXP_SQ;
      ST_EXP_SQ:    state_next = sts.d_last ? ST_DONE : ST_MULB_WAIT;
      ST_MULB_WAIT: if (sts.mul_done) state_next = ST_EXP_CHECK;
      ST_DONE:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_EUC;
    cmd.mul_sel = MUL_ANS;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      ST_KEY_N: cmd.key_mul_n = 1'b1;
      ST_KEY_T: cmd.key_mul_t = 1'b1;
      ST_EUC_INIT: begin
        cmd.pe_clear = sts.tot_zero;
        cmd.euc_init = !sts.tot_zero;
      end
      ST_EUC_TEST: cmd.div_start = !sts.r1_zero;
      ST_EUC_WAIT: cmd.euc_upd = sts.div_done;
      ST_INV_START: begin
        cmd.div_sel   = DIV_INV;
        cmd.div_start = 1'b1;
      end
      ST_INV_WAIT: begin
        cmd.div_sel = DIV_INV;
        cmd.inv_fix = sts.div_done;
      end
      ST_KEY_DONE: cmd.key_set = 1'b1;
      ST_RED_START: begin
        cmd.div_sel   = DIV_RED;
        cmd.div_start = !(sts.pe_zero || sts.mod_zero);
      end
      ST_RED_WAIT: begin
        cmd.div_sel  = DIV_RED;
        cmd.red_load = sts.div_done;
      end
      ST_EXP_CHECK: cmd.mul_start = sts.d_lsb;
      ST_MULA_WAIT: cmd.mul_wb = sts.mul_done;
      ST_EXP_SQ: begin
        cmd.d_shift   = 1'b1;
        cmd.mul_sel   = MUL_SQ;
        cmd.mul_start = !sts.d_last;
      end
      ST_MULB_WAIT: begin
        cmd.mul_sel = MUL_SQ;
        cmd.mul_wb  = sts.mul_done;
      end
      ST_DONE: cmd.out_push = out_free;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

[rtl/rsa_decrypt_from_primes_top.sv]
// Top level: APB register file, controller, datapath and output register.
// Depends on rdp_pkg, rdp_ctrl, rdp_dp.
//
// channel    dir  fields                       transfer when
// s_axis     in   tdata[62:0] ciphertext       s_tvalid & s_tready
// m_axis     out  tdata[61:0] plaintext        m_tvalid & m_tready
// apb        in   regs e @0, p @4, q @8        psel & penable & pwrite
//
// The first item after reset or a write to e, p or q derives the key: n and
// the totient, then Euclid steps on the divider (one bit a cycle), then the inverse.
// Per item: the ciphertext is reduced mod n, then per exponent bit up to two
// bit-serial multiplies, square-and-multiply from the exponent LSB.
// Reset is synchronous; the next item is taken while a result waits.
`default_nettype none
module rsa_decrypt_from_primes_top #(
  parameter int MODULUS_BITS = 62
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [62:0] ciphertext
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,   // [61:0] plaintext
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import rdp_pkg::*;

  logic [31:0] pub_e;
  logic [30:0] prime_p, prime_q;
  logic        wr, cfg_clear, out_free;
  logic [MODULUS_BITS-1:0] result;
  cmd_t    cmd;
  status_t sts;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign cfg_clear = wr && (paddr[3:2] != 2'd3);
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pub_e   <= 32'd17;
      prime_p <= 31'd61;
      prime_q <= 31'd53;
    end else if (wr) begin
      case (paddr[3:2])
        2'd0:    pub_e   <= pwdata;
        2'd1:    prime_p <= pwdata[30:0];
        2'd2:    prime_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      2'd0:    prdata = pub_e;
      2'd1:    prdata = {1'b0, prime_p};
      2'd2:    prdata = {1'b0, prime_q};
      default: prdata = '0;
    endcase
  end

  rdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdp_dp #(.MB(MODULUS_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_clear  (cfg_clear),
    .pub_e      (pub_e),
    .prime_p    (prime_p),
    .prime_q    (prime_q),
    .ciphertext (s_tdata[CT_W-1:0]),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) m_tdata <= {2'b00, 62'(result)};
  end
endmodule
`default_nettype wire

[rtl/rdp_checker.sv]
// Port-level checker for the top level, attached by bind.
// Depends on rsa_decrypt_from_primes_top.
`default_nettype none
module rdp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:62] == 2'b00)
    else $error("plaintext padding not zero");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind rsa_decrypt_from_primes_top rdp_checker u_rdp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);
`default_nettype wire
